// ===== src/slt_pkg.sv =====
// shared types and constants for the serial light and trigger controller
`timescale 1ns / 1ps

package slt_pkg;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_FAST = 2'd1;
   localparam logic [1:0] KIND_SLOW = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [7:0] CMD_TRIGGER = 8'h58;
   localparam logic [7:0] CMD_DARK    = 8'h30;
   localparam logic [7:0] CMD_LIGHT   = 8'h31;
   localparam logic [7:0] CMD_TIMED   = 8'h74;

   localparam logic [15:0] PULSE_TICKS_RESET = 16'd256;
   localparam logic [8:0]  DARK_FULL         = 9'd256;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       lamps_lit;
      logic       trigger_high;
   } rsp_type;

endpackage

// ===== src/slt_core.sv =====
// command decode, light and trigger state, pulse and dark counters
`timescale 1ns / 1ps

module slt_core
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_word,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output rsp_type     rsp_word
);

   logic        awaiting_ff, awaiting_in;
   logic        light_ff, light_in;
   logic        trigger_ff, trigger_in;
   logic [15:0] pulse_ff, pulse_in;
   logic        dark_timing_ff, dark_timing_in;
   logic [8:0]  dark_ff, dark_in;
   logic [15:0] pulse_ticks_ff;

   always_comb begin
      awaiting_in    = awaiting_ff;
      light_in       = light_ff;
      trigger_in     = trigger_ff;
      pulse_in       = pulse_ff;
      dark_timing_in = dark_timing_ff;
      dark_in        = dark_ff;
      case (req_word.kind)
         KIND_BYTE: begin
            if (awaiting_ff) begin
               awaiting_in    = 1'b0;
               dark_in        = (req_word.data_byte == 8'd0) ? DARK_FULL
                                                             : {1'b0, req_word.data_byte};
               dark_timing_in = 1'b1;
               light_in       = 1'b0;
            end else begin
               case (req_word.data_byte)
                  CMD_TRIGGER: begin
                     trigger_in = 1'b1;
                     pulse_in   = pulse_ticks_ff;
                  end
                  CMD_DARK: begin
                     dark_timing_in = 1'b0;
                     dark_in        = 9'd0;
                     light_in       = 1'b0;
                  end
                  CMD_LIGHT: begin
                     dark_timing_in = 1'b0;
                     dark_in        = 9'd0;
                     light_in       = 1'b1;
                  end
                  CMD_TIMED: begin
                     awaiting_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_FAST: begin
            if (trigger_ff) begin
               if (pulse_ff <= 16'd1) begin
                  pulse_in   = 16'd0;
                  trigger_in = 1'b0;
               end else begin
                  pulse_in = pulse_ff - 16'd1;
               end
            end
         end
         KIND_SLOW: begin
            if (dark_timing_ff) begin
               if (dark_ff <= 9'd1) begin
                  dark_in        = 9'd0;
                  dark_timing_in = 1'b0;
                  light_in       = 1'b1;
               end else begin
                  dark_in = dark_ff - 9'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_word.echo_valid   = (req_word.kind == KIND_BYTE);
      rsp_word.echo_byte    = (req_word.kind == KIND_BYTE) ? req_word.data_byte : 8'd0;
      rsp_word.lamps_lit    = light_in;
      rsp_word.trigger_high = trigger_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff    <= 1'b0;
         light_ff       <= 1'b1;
         trigger_ff     <= 1'b0;
         pulse_ff       <= 16'd0;
         dark_timing_ff <= 1'b0;
         dark_ff        <= 9'd0;
      end else if (accept) begin
         awaiting_ff    <= awaiting_in;
         light_ff       <= light_in;
         trigger_ff     <= trigger_in;
         pulse_ff       <= pulse_in;
         dark_timing_ff <= dark_timing_in;
         dark_ff        <= dark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff <= PULSE_TICKS_RESET;
      end else if (csr_write_enable) begin
         pulse_ticks_ff <= csr_write_data;
      end
   end

endmodule

// ===== src/slt_out_buf.sv =====
// result register with a skid entry
`timescale 1ns / 1ps

module slt_out_buf
   import slt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_word
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff       <= in_word;
            skid_valid_ff <= 1'b1;
         end else begin
            main_ff       <= in_word;
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

// ===== src/serial_light_trigger_controller.sv =====
// a word accepted into an empty buffer shows its result at rsp the next cycle
// throughput: one word per cycle while the skid entry is empty
// a two-entry result buffer keeps req_ready high while one result waits
// reset: synchronous, lights on, trigger low, timers stopped, pulse length 256
`timescale 1ns / 1ps

module serial_light_trigger_controller
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   rsp_type result;
   logic    accept;

   assign accept = req_valid && req_ready;

   slt_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_word         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_word         (result)
   );

   slt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_data)
   );

endmodule

// ===== src/slt_checker.sv =====
// port-level checks for the controller and the bind that attaches them
`timescale 1ns / 1ps

module slt_port_checker
   import slt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_type     rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.echo_valid |-> rsp_data.echo_byte == 8'd0)
      else $error("echo byte without echo");

   a_empty_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result missing one cycle after accept");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind serial_light_trigger_controller slt_port_checker u_slt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_data         (rsp_data)
);

// ===== test/slt_checker.sv =====
// checker for the serial light and trigger controller: predicts and compares every result word
`timescale 1ns / 1ps

module slt_checker
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output int          mismatches,
   output int          pending
);

   logic [15:0] pulse_len;
   logic        wait_duration;
   logic        lit;
   logic        trig;
   logic [15:0] pulse_left;
   logic        dark_run;
   logic [8:0]  dark_left;

   rsp_type expected_levels[$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic rsp_type controller_step(input req_type w);
      rsp_type r;
      r = '0;
      case (w.kind)
         KIND_BYTE: begin
            r.echo_valid = 1'b1;
            r.echo_byte = w.data_byte;
            if (wait_duration) begin
               wait_duration = 1'b0;
               dark_left = (w.data_byte == 8'd0) ? DARK_FULL : {1'b0, w.data_byte};
               dark_run = 1'b1;
               lit = 1'b0;
            end else begin
               case (w.data_byte)
                  CMD_TRIGGER: begin
                     trig = 1'b1;
                     pulse_left = pulse_len;
                  end
                  CMD_DARK: begin
                     dark_run = 1'b0;
                     dark_left = '0;
                     lit = 1'b0;
                  end
                  CMD_LIGHT: begin
                     dark_run = 1'b0;
                     dark_left = '0;
                     lit = 1'b1;
                  end
                  CMD_TIMED: wait_duration = 1'b1;
                  default: ;
               endcase
            end
         end
         KIND_FAST: begin
            if (trig) begin
               if (pulse_left <= 16'd1) begin
                  pulse_left = '0;
                  trig = 1'b0;
               end else begin
                  pulse_left = pulse_left - 16'd1;
               end
            end
         end
         KIND_SLOW: begin
            if (dark_run) begin
               if (dark_left <= 9'd1) begin
                  dark_left = '0;
                  dark_run = 1'b0;
                  lit = 1'b1;
               end else begin
                  dark_left = dark_left - 9'd1;
               end
            end
         end
         default: ;
      endcase
      r.lamps_lit = lit;
      r.trigger_high = trig;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pulse_len = PULSE_TICKS_RESET;
         wait_duration = 1'b0;
         lit = 1'b1;
         trig = 1'b0;
         pulse_left = '0;
         dark_run = 1'b0;
         dark_left = '0;
         expected_levels.delete();
      end else begin
         if (req_valid && req_ready)
            expected_levels.push_back(controller_step(req_data));
         if (csr_write_enable)
            pulse_len = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word expected none actual %h", $time, rsp_data);
            end else begin
               want = expected_levels.pop_front();
               check_field("echo_valid", {7'd0, want.echo_valid}, {7'd0, rsp_data.echo_valid});
               check_field("echo_byte", want.echo_byte, rsp_data.echo_byte);
               check_field("lamps_lit", {7'd0, want.lamps_lit}, {7'd0, rsp_data.lamps_lit});
               check_field("trigger_high", {7'd0, want.trigger_high},
                           {7'd0, rsp_data.trigger_high});
            end
         end
      end
      pending = expected_levels.size();
   end

endmodule

// ===== test/tb.sv =====
// testbench top for the serial light and trigger controller: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb
   import slt_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   int mismatches;
   int pending;
   int cycles = 0;
   int burst_left = 0;
   int words_sent = 0;
   int stall_mode = 0;
   int stall_age = 0;

   serial_light_trigger_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   slt_checker levels_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver stalls: the mode is picked anew at random whenever its age counter runs out
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_age <= $urandom_range(16, 96);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic put_word(input logic [1:0] kind, input logic [7:0] b);
      logic got;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, data_byte: b};
      do begin
         @(negedge clock);
         got = req_ready;
         @(posedge clock);
      end while (!got);
      burst_left--;
      if (kind != KIND_NONE)
         words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      wait (pending == 0);
      @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_pulse_len(input logic [15:0] v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_sequence();
      int pick;
      int n;
      int dur;
      int i;
      logic [7:0] b;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         put_word(KIND_BYTE, CMD_TRIGGER);
         n = $urandom_range(0, 6);
         for (i = 0; i < n; i++)
            put_word(($urandom_range(0, 4) == 0) ? KIND_SLOW : KIND_FAST, 8'($urandom));
      end else if (pick < 6) begin
         put_word(KIND_BYTE, CMD_TIMED);
         case ($urandom_range(0, 31))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(1, 5));
         endcase
         put_word(KIND_BYTE, b);
         dur = (b == 8'h00) ? 256 : b;
         n = (dur > 5) ? $urandom_range(0, 6) : $urandom_range(0, dur + 2);
         for (i = 0; i < n; i++)
            put_word(($urandom_range(0, 4) == 0) ? KIND_FAST : KIND_SLOW, 8'($urandom));
      end else if (pick == 6) begin
         put_word(KIND_BYTE, $urandom_range(0, 1) ? CMD_DARK : CMD_LIGHT);
      end else if (pick == 7) begin
         // command byte lands where the duration is taken
         put_word(KIND_BYTE, CMD_TIMED);
         case ($urandom_range(0, 3))
            0: b = CMD_TRIGGER;
            1: b = CMD_DARK;
            2: b = CMD_LIGHT;
            default: b = CMD_TIMED;
         endcase
         put_word(KIND_BYTE, b);
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            put_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   initial begin
      logic [15:0] pulse_settings [6];
      int p;
      int i;
      int target;
      pulse_settings = '{16'd1, 16'd3, 16'hFFFF, 16'd0, 16'd2, 16'd7};
      pulse_settings[5] = 16'($urandom_range(4, 40));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset pulse length
      put_word(KIND_BYTE, CMD_TRIGGER);
      put_word(KIND_FAST, 8'h00);
      put_word(KIND_BYTE, CMD_TRIGGER);
      put_word(KIND_FAST, 8'hFF);
      put_word(KIND_BYTE, CMD_DARK);
      put_word(KIND_BYTE, CMD_LIGHT);
      put_word(KIND_SLOW, 8'h00);
      put_word(KIND_BYTE, CMD_TIMED);
      put_word(KIND_BYTE, 8'h00);
      // full dark of 256 slow ticks, lit again on the last one
      for (i = 0; i < 256; i++)
         put_word(KIND_SLOW, 8'(i));
      put_word(KIND_BYTE, CMD_LIGHT);
      put_word(KIND_BYTE, CMD_TIMED);
      put_word(KIND_BYTE, CMD_TIMED);
      put_word(KIND_BYTE, CMD_DARK);
      put_word(KIND_BYTE, CMD_TIMED);
      put_word(KIND_BYTE, 8'hFF);
      put_word(KIND_BYTE, CMD_TIMED);
      put_word(KIND_BYTE, 8'h01);
      put_word(KIND_SLOW, 8'h00);
      put_word(KIND_BYTE, 8'hA5);
      put_word(KIND_NONE, 8'hFF);

      write_pulse_len(16'd1);
      put_word(KIND_BYTE, CMD_TRIGGER);
      put_word(KIND_FAST, 8'h00);
      put_word(KIND_FAST, 8'h00);

      for (p = 0; p < 6; p++) begin
         write_pulse_len(pulse_settings[p]);
         target = words_sent + 40;
         while (words_sent < target) begin
            random_sequence();
            if (p == 1 && words_sent >= target - 20 && words_sent < target - 10)
               settle();
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
